// ----- rtl/fpmd_pkg.sv -----
// Shared types and constants of the fixed-point multiply/divide unit.
// Depends on nothing.
package fpmd_pkg;

  typedef enum logic [1:0] {
    MODE_RMUL  = 2'd0,
    MODE_MSHR  = 2'd1,
    MODE_DIV   = 2'd2,
    MODE_SCALE = 2'd3
  } mode_e;

  typedef struct packed {
    logic [1:0]  mode;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
    logic [5:0]  shift_amount;
    logic signed [31:0] divisor;
  } in_t;

  typedef struct packed {
    logic [31:0] result;
    logic        divide_by_zero;
  } out_t;

  // Work handed from front to back: mode, a 64-bit product or dividend, shift amount and divisor.
  typedef struct packed {
    mode_e       mode;
    logic [63:0] prod;
    logic [5:0]  shift_amount;
    logic signed [31:0] dvsr;
  } work_t;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = 1;
  localparam int unsigned DivStages  = 64;
  localparam logic [63:0] RoundHalf  = 64'h0000_0000_0000_8000;
  localparam logic [31:0] SatPos     = 32'h7FFF_FFFF;
  localparam logic [31:0] SatNeg     = 32'h8000_0000;

endpackage

// ----- rtl/fpmd_front.sv -----
// Front part: accepts transactions, forms the 64-bit product or dividend.
// Depends on fpmd_pkg.
module fpmd_front import fpmd_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  output logic  stall_o,
  input  in_t   data_i,
  output logic  valid_o,
  input  logic  stall_i,
  output work_t work_o
);

  logic  valid_q, valid_d;
  work_t work_q, work_d;
  logic  take;

  assign stall_o = valid_q && stall_i;
  assign take    = valid_i && !stall_o;

  always_comb begin
    valid_d = valid_q;
    if (!stall_o) begin
      valid_d = valid_i;
    end
    work_d              = work_q;
    work_d.mode         = mode_e'(data_i.mode);
    work_d.shift_amount = data_i.shift_amount;
    work_d.dvsr         = (data_i.mode == MODE_DIV) ? data_i.operand_b : data_i.divisor;
    if (data_i.mode == MODE_DIV) begin
      work_d.prod = {{16{data_i.operand_a[31]}}, data_i.operand_a, 16'h0000};
    end else begin
      work_d.prod = 64'($signed(data_i.operand_a) * $signed(data_i.operand_b));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      work_q <= work_d;
    end
  end

  assign valid_o = valid_q;
  assign work_o  = work_q;

endmodule

// ----- rtl/fpmd_queue.sv -----
// Short queue between front and back parts.
// Depends on fpmd_pkg.
module fpmd_queue import fpmd_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  output logic  stall_o,
  input  work_t data_i,
  output logic  valid_o,
  input  logic  stall_i,
  output work_t data_o
);

  work_t mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QueuePtrW:0]   cnt_q, cnt_d;
  logic push, pop;

  assign stall_o = (cnt_q == (QueuePtrW+1)'(QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign push    = valid_i && !stall_o;
  assign pop     = valid_o && !stall_i;
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = push ? wr_q + 1'b1 : wr_q;
    rd_d  = pop ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + (QueuePtrW+1)'(push) - (QueuePtrW+1)'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

// ----- rtl/fpmd_back.sv -----
// Back part: pipelined radix-2 signed divider (64 by 32) plus multiply paths.
// Depends on fpmd_pkg.
module fpmd_back import fpmd_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  output logic  stall_o,
  input  work_t work_i,
  output logic  valid_o,
  input  logic  stall_i,
  output out_t  data_o
);

  // One quotient bit per stage on magnitudes; signs ride along.
  typedef struct packed {
    logic [31:0] mul_res;
    logic        is_div;
    logic        dz;
    logic        neg_q;
    logic        neg_p;
    logic [63:0] quo;   // dividend shifting out, quotient shifting in
    logic [32:0] rem;
    logic [31:0] dmag;
  } stg_t;

  logic [DivStages:0] vld_q;
  stg_t               stg_q [DivStages+1];
  stg_t               stg_d [DivStages+1];
  logic               adv;
  logic [63:0]        pmag;
  logic [63:0]        qfin;
  logic [31:0]        div_res;

  assign adv     = !(vld_q[DivStages] && stall_i);
  assign stall_o = !adv;

  always_comb begin
    stg_d[0].is_div  = (work_i.mode == MODE_DIV) || (work_i.mode == MODE_SCALE);
    stg_d[0].dz      = stg_d[0].is_div && (work_i.dvsr == '0);
    stg_d[0].neg_p   = work_i.prod[63];
    stg_d[0].neg_q   = work_i.prod[63] ^ work_i.dvsr[31];
    pmag             = work_i.prod[63] ? (~work_i.prod + 64'd1) : work_i.prod;
    stg_d[0].quo     = pmag;
    stg_d[0].rem     = '0;
    stg_d[0].dmag    = work_i.dvsr[31] ? (~work_i.dvsr + 32'd1) : work_i.dvsr;
    if (work_i.mode == MODE_RMUL) begin
      stg_d[0].mul_res = 32'((work_i.prod + RoundHalf) >> 16);
    end else begin
      stg_d[0].mul_res = 32'(work_i.prod >> work_i.shift_amount);
    end
  end

  for (genvar s = 1; s <= DivStages; s++) begin : g_stage
    logic [33:0] trial;
    always_comb begin
      stg_d[s] = stg_q[s-1];
      trial    = {stg_q[s-1].rem, stg_q[s-1].quo[63]} - {2'b00, stg_q[s-1].dmag};
      if (!trial[33]) begin
        stg_d[s].rem = trial[32:0];
        stg_d[s].quo = {stg_q[s-1].quo[62:0], 1'b1};
      end else begin
        stg_d[s].rem = {stg_q[s-1].rem[31:0], stg_q[s-1].quo[63]};
        stg_d[s].quo = {stg_q[s-1].quo[62:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[DivStages-1:0], valid_i};
    end
  end

  for (genvar s = 0; s <= DivStages; s++) begin : g_reg
    always_ff @(posedge clk_i) begin
      if (adv) begin
        stg_q[s] <= stg_d[s];
      end
    end
  end

  always_comb begin
    qfin = stg_q[DivStages].neg_q ? (~stg_q[DivStages].quo + 64'd1) : stg_q[DivStages].quo;
    if (stg_q[DivStages].dz) begin
      div_res = stg_q[DivStages].neg_p ? SatNeg : SatPos;
    end else begin
      div_res = qfin[31:0];
    end
    data_o.result         = stg_q[DivStages].is_div ? div_res : stg_q[DivStages].mul_res;
    data_o.divide_by_zero = stg_q[DivStages].dz;
  end

  assign valid_o = vld_q[DivStages];

endmodule

// ----- rtl/fixed_point_mul_div_unit.sv -----
// Q16.16 fixed-point multiply/divide unit, top level.
// Path from input to output: front register, queue, back input register, 64 divider stages.
// Throughput: one transaction per cycle unless stalled; the divider sets the latency.
// Reset: asynchronous, active low; clears all valid flags, payloads are not reset.
// Depends on fpmd_pkg, fpmd_front, fpmd_queue, fpmd_back.
module fixed_point_mul_div_unit import fpmd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  // The front forms the product (or shifted dividend) for every transaction.
  logic  f_valid, f_stall;
  work_t f_work;
  // The queue lets the divider pipeline stall independently of the front.
  logic  q_valid, q_stall;
  work_t q_work;

  fpmd_front u_front (
    .clk_i, .rst_ni,
    .valid_i(in_valid_i), .stall_o(in_stall_o), .data_i(in_data_i),
    .valid_o(f_valid), .stall_i(f_stall), .work_o(f_work)
  );

  fpmd_queue u_queue (
    .clk_i, .rst_ni,
    .valid_i(f_valid), .stall_o(f_stall), .data_i(f_work),
    .valid_o(q_valid), .stall_i(q_stall), .data_o(q_work)
  );

  // The back part divides or selects the multiply result and holds it for the consumer.
  fpmd_back u_back (
    .clk_i, .rst_ni,
    .valid_i(q_valid), .stall_o(q_stall), .work_i(q_work),
    .valid_o(out_valid_o), .stall_i(out_stall_i), .data_o(out_data_o)
  );

endmodule

// ----- tb/fixed_point_mul_div_unit_tb.sv -----
// Self-checking testbench for the Q16.16 fixed-point multiply/divide unit.
// Depends on fpmd_pkg and fixed_point_mul_div_unit; predicts each result internally.
`timescale 1ns / 100ps

module fixed_point_mul_div_unit_tb;
  import fpmd_pkg::*;

  localparam int NumRandom = 1700;
  localparam int StallLimit = 20000;
  localparam int DrainCycles = 100;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_t out_data_o;

  // Operations waiting to be sent, and results predicted for sent operations.
  in_t pending_ops[$];
  out_t predicted_results[$];
  int errors = 0;
  int ops_sent = 0;
  int results_seen = 0;
  int dz_seen = 0;
  int idle_cycles = 0;
  int send_gap = 0;
  int recv_gap = 0;
  bit stimulus_done = 1'b0;

  fixed_point_mul_div_unit dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_data_i(in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o(out_data_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Computes the arithmetic result with exact 64-bit signed intermediates.
  function automatic out_t compute_fixed_op(in_t op);
    logic signed [63:0] a;
    logic signed [63:0] b;
    logic signed [63:0] d;
    logic signed [63:0] product;
    logic signed [63:0] quotient;
    logic [63:0] widened;
    out_t r;
    a = op.operand_a;
    b = op.operand_b;
    d = op.divisor;
    product = a * b;
    r = '0;
    case (mode_e'(op.mode))
      MODE_RMUL: begin
        widened = (product + RoundHalf) >> 16;
        r.result = widened[31:0];
      end
      MODE_MSHR: begin
        widened = product;
        widened = widened >> op.shift_amount;
        r.result = widened[31:0];
      end
      MODE_DIV: begin
        if (b == 0) begin
          r.divide_by_zero = 1'b1;
          r.result = (a < 0) ? SatNeg : SatPos;
        end else begin
          // SystemVerilog signed division truncates toward zero, as required.
          quotient = (a <<< 16) / b;
          r.result = quotient[31:0];
        end
      end
      default: begin
        if (d == 0) begin
          r.divide_by_zero = 1'b1;
          r.result = (product < 0) ? SatNeg : SatPos;
        end else begin
          quotient = product / d;
          r.result = quotient[31:0];
        end
      end
    endcase
    return r;
  endfunction

  // Picks an operand biased toward edge values and sparse bit patterns.
  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      3: return 32'h0001_0000 * $urandom_range(0, 15);
      4: return -($urandom_range(0, 3000));
      5: return $urandom_range(0, 3000);
      6: return 32'h1 << $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  // Returns a gap length: mostly zero, often short, occasionally long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic in_t make_op(mode_e m, logic [31:0] a, logic [31:0] b,
                                  logic [5:0] sh, logic [31:0] d);
    in_t op;
    op.mode = m;
    op.operand_a = a;
    op.operand_b = b;
    op.shift_amount = sh;
    op.divisor = d;
    return op;
  endfunction

  initial begin
    in_t op;
    // Directed transactions: extremes, every mode, and both zero-divisor cases.
    pending_ops.push_back(make_op(MODE_RMUL, 32'h0001_8000, 32'h0002_0000, 6'd0, 32'd0));
    pending_ops.push_back(make_op(MODE_RMUL, 32'h8000_0000, 32'h8000_0000, 6'd63, 32'd1));
    pending_ops.push_back(make_op(MODE_RMUL, 32'hFFFF_FFFF, 32'h0000_8000, 6'd0, 32'd0));
    pending_ops.push_back(make_op(MODE_RMUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 6'd0, 32'hFFFF_FFFF));
    pending_ops.push_back(make_op(MODE_MSHR, 32'h8000_0000, 32'h7FFF_FFFF, 6'd0, 32'd0));
    pending_ops.push_back(make_op(MODE_MSHR, 32'hFFFF_FFFF, 32'h0000_0001, 6'd63, 32'd0));
    pending_ops.push_back(make_op(MODE_MSHR, 32'h8000_0000, 32'h8000_0000, 6'd32, 32'd0));
    pending_ops.push_back(make_op(MODE_MSHR, 32'hFFFF_FFFF, 32'h0000_0003, 6'd31, 32'd0));
    pending_ops.push_back(make_op(MODE_DIV, 32'h0001_0000, 32'h0003_0000, 6'd5, 32'd0));
    pending_ops.push_back(make_op(MODE_DIV, 32'h8000_0000, 32'hFFFF_FFFF, 6'd0, 32'd0));
    pending_ops.push_back(make_op(MODE_DIV, 32'h7FFF_FFFF, 32'h0000_0001, 6'd0, 32'd0));
    pending_ops.push_back(make_op(MODE_DIV, 32'hFFFF_FFF9, 32'h0000_0002, 6'd0, 32'd0));
    pending_ops.push_back(make_op(MODE_DIV, 32'h0000_0000, 32'h0000_0000, 6'd0, 32'd0));
    pending_ops.push_back(make_op(MODE_DIV, 32'h8000_0000, 32'h0000_0000, 6'd0, 32'd0));
    pending_ops.push_back(make_op(MODE_DIV, 32'h0000_0005, 32'h0000_0000, 6'd0, 32'd7));
    pending_ops.push_back(make_op(MODE_SCALE, 32'h0000_0007, 32'h0000_0003, 6'd0, 32'h2));
    pending_ops.push_back(make_op(MODE_SCALE, 32'h8000_0000, 32'h8000_0000, 6'd0, 32'h1));
    pending_ops.push_back(make_op(MODE_SCALE, 32'h8000_0000, 32'h8000_0000, 6'd0,
                                  32'h8000_0000));
    pending_ops.push_back(make_op(MODE_SCALE, 32'hFFFF_FFF9, 32'h0000_0001, 6'd0, 32'h2));
    pending_ops.push_back(make_op(MODE_SCALE, 32'h0000_0003, 32'hFFFF_FFFF, 6'd9, 32'h0));
    pending_ops.push_back(make_op(MODE_SCALE, 32'h0000_0000, 32'h8000_0000, 6'd9, 32'h0));
    pending_ops.push_back(make_op(MODE_SCALE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 6'd0, 32'h0));
    pending_ops.push_back(make_op(MODE_SCALE, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 6'd0,
                                  32'hFFFF_FFFF));

    // Random transactions.  Divisors are zero now and then to hit saturation.
    for (int i = 0; i < NumRandom; i++) begin
      op.mode = 2'($urandom_range(0, 3));
      op.operand_a = pick_operand();
      op.operand_b = ($urandom_range(0, 15) == 0) ? 32'd0 : pick_operand();
      op.shift_amount = 6'($urandom_range(0, 63));
      op.divisor = ($urandom_range(0, 15) == 0) ? 32'd0 : pick_operand();
      pending_ops.push_back(op);
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (pending_ops.size() == 0 && !in_valid_i);
    stimulus_done = 1'b1;
  end

  // Driver: presents the next transaction after a random gap and holds it while stalled.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        predicted_results.push_back(compute_fixed_op(in_data_i));
        ops_sent <= ops_sent + 1;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (send_gap > 0 || pending_ops.size() == 0) begin
          in_valid_i <= 1'b0;
          if (send_gap > 0) send_gap <= send_gap - 1;
        end else begin
          in_valid_i <= 1'b1;
          in_data_i <= pending_ops.pop_front();
          send_gap <= pick_gap();
        end
      end
    end
  end

  // Monitor: compares each accepted result with the oldest prediction.
  always @(posedge clk_i) begin
    out_t exp_r;
    int miss;
    miss = 0;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        results_seen <= results_seen + 1;
        if (predicted_results.size() == 0) begin
          $error("result transaction with no prediction pending: %h", out_data_o);
          miss = miss + 1;
        end else begin
          exp_r = predicted_results.pop_front();
          if (exp_r.divide_by_zero) dz_seen <= dz_seen + 1;
          if (out_data_o.result !== exp_r.result) begin
            $error("result: expected %h, got %h", exp_r.result, out_data_o.result);
            miss = miss + 1;
          end
          if (out_data_o.divide_by_zero !== exp_r.divide_by_zero) begin
            $error("divide_by_zero: expected %b, got %b",
                   exp_r.divide_by_zero, out_data_o.divide_by_zero);
            miss = miss + 1;
          end
        end
      end
      errors <= errors + miss;
      // Receiver back-pressure: stall runs of random length, with stall-free stretches.
      if (recv_gap > 0) begin
        out_stall_i <= 1'b1;
        recv_gap <= recv_gap - 1;
      end else begin
        out_stall_i <= 1'b0;
        recv_gap <= pick_gap();
      end
    end
  end

  // Watchdog: counts cycles in which neither channel accepts a transaction.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= StallLimit) begin
      $display("watchdog: no transaction for %0d cycles", StallLimit);
      $display("FAILURE");
      $finish;
    end
  end

  // End of test: drain predictions, allow the pipeline to settle, then report.
  initial begin
    bit leftover;
    leftover = 1'b0;
    wait (stimulus_done);
    wait (predicted_results.size() == 0);
    repeat (DrainCycles) @(posedge clk_i);
    if (predicted_results.size() != 0) begin
      $error("%0d predicted results never arrived", predicted_results.size());
      leftover = 1'b1;
    end
    $display("Covered %0d operations over all four modes; %0d results checked,",
             ops_sent, results_seen);
    $display("%0d of them saturated on a zero divisor; %0d mismatches.", dz_seen, errors);
    if (errors == 0 && !leftover) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/fpmd_pkg.sv
rtl/fpmd_front.sv
rtl/fpmd_queue.sv
rtl/fpmd_back.sv
rtl/fixed_point_mul_div_unit.sv
tb/fixed_point_mul_div_unit_tb.sv
